[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl files
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[hw/rtl/lsom_pkg.sv]
// types, codes and widths of the layer stack order manager
// no dependencies; used by lsom_cell and layer_stack_order_manager
package lsom_pkg;

  localparam int LAYERS = 32;
  localparam int LW     = $clog2(LAYERS);
  localparam int HW     = LW + 1;

  typedef logic [LW-1:0]        layer_t;
  typedef logic signed [HW-1:0] height_t;

  // operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOT_USED = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // shift direction for the cells inside the move range
  typedef enum logic [1:0] {
    SH_NONE,
    SH_UP,   // take the entry of the position below
    SH_DN    // take the entry of the position above
  } shift_t;

  // control broadcast to every cell
  typedef struct packed {
    shift_t           mode;
    logic [HW-1:0]    lo;
    logic [HW-1:0]    hi;
    logic             wr_en;
    layer_t           wr_pos;
    layer_t           wr_layer;
  } cell_ctrl_t;

endpackage

[hw/rtl/lsom_cell.sv]
// one stacking position: holds the layer at that position and shifts with
// its neighbors; depends on lsom_pkg
module lsom_cell (
  input  logic                clk,
  input  lsom_pkg::cell_ctrl_t ctrl,
  input  lsom_pkg::layer_t    cell_pos,
  input  lsom_pkg::layer_t    look_layer,
  input  lsom_pkg::height_t   top,
  input  lsom_pkg::layer_t    below_entry,
  input  lsom_pkg::layer_t    above_entry,
  output lsom_pkg::layer_t    entry,
  output logic                hit
);
  import lsom_pkg::*;

  layer_t        entry_r;
  layer_t        entry_nxt;
  logic [HW-1:0] pos_ext;
  logic          in_range;

  assign pos_ext  = {1'b0, cell_pos};
  assign in_range = (pos_ext >= ctrl.lo) && (pos_ext <= ctrl.hi);

  // write of the moved layer wins over the shift
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.wr_en && (cell_pos == ctrl.wr_pos)) begin
      entry_nxt = ctrl.wr_layer;
    end else if (in_range) begin
      case (ctrl.mode)
        SH_UP:   entry_nxt = below_entry;
        SH_DN:   entry_nxt = above_entry;
        default: entry_nxt = entry_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // lookup match, only positions up to the top are live
  assign entry = entry_r;
  assign hit   = (entry_r == look_layer) && ($signed(pos_ext) <= top);

endmodule

[hw/rtl/layer_stack_order_manager.sv]
// top level of the layer stack order manager: control, pool bits and the
// row of position cells; depends on lsom_pkg, lsom_cell, assert_macros.svh
//
//  channel | ports                                              | dir
//  --------+----------------------------------------------------+-----
//  in      | in_valid in_ready in_op in_layer in_requested_height | in
//  out     | out_valid out_ready out_status out_layer_id         | out
//          | out_layer_height out_top_height out_needs_redraw    |
//
// one transaction per cycle while the output is not stalled: each operation is decoded, looked up in the
// cell row and applied in the cycle it is accepted; the cells' parallel
// range compare and one-step shift set that figure.
// the result sits in an output register in the cycle after acceptance.
// a stalled result holds, and input is taken again in the cycle it leaves.
// reset frees all layers and empties the stack; no clearing pass.
`include "assert_macros.svh"

module layer_stack_order_manager (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_op,
  input  lsom_pkg::layer_t        in_layer,
  input  logic signed [8:0]       in_requested_height,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output lsom_pkg::layer_t        out_layer_id,
  output lsom_pkg::height_t       out_layer_height,
  output lsom_pkg::height_t       out_top_height,
  output logic                    out_needs_redraw
);
  import lsom_pkg::*;

  // state
  height_t           top_r, top_nxt;
  logic [LAYERS-1:0] in_use_r, in_use_nxt;
  logic              out_valid_r;
  logic [1:0]        status_r, status_nxt;
  layer_t            id_r, id_nxt;
  height_t           lh_r, lh_nxt;
  logic              redraw_r, redraw_nxt;

  // cell row
  cell_ctrl_t        ctrl;
  layer_t            entries [LAYERS];
  logic [LAYERS-1:0] hits;

  logic              fire;
  logic              valid_layer;
  logic              shown;
  logic [LW-1:0]     old_pos;
  height_t           old_h;
  height_t           limit;
  logic signed [9:0] req_x, lim_x, h_x;
  height_t           tgt;
  logic              moving;
  logic              rd_ok;
  logic              free_found;
  layer_t            free_idx;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  // the position cells
  for (genvar p = 0; p < LAYERS; p++) begin : g_cell
    layer_t below_e, above_e;
    if (p == 0) begin : g_lo
      assign below_e = '0;
    end else begin : g_lo
      assign below_e = entries[p-1];
    end
    if (p == LAYERS - 1) begin : g_hi
      assign above_e = '0;
    end else begin : g_hi
      assign above_e = entries[p+1];
    end
    lsom_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .cell_pos    (LW'(p)),
      .look_layer  (in_layer),
      .top         (top_r),
      .below_entry (below_e),
      .above_entry (above_e),
      .entry       (entries[p]),
      .hit         (hits[p])
    );
  end

  // current height of the addressed layer from the cell matches
  always_comb begin
    old_pos = '0;
    for (int i = 0; i < LAYERS; i++) begin
      if (hits[i]) old_pos = old_pos | LW'(i);
    end
  end
  assign shown       = |hits;
  assign old_h       = shown ? $signed({1'b0, old_pos}) : '1;
  assign valid_layer = in_use_r[in_layer];

  // clamp the requested height
  assign limit = shown ? top_r : HW'(top_r + HW'(1));
  assign req_x = 10'(in_requested_height);
  assign lim_x = 10'(limit);
  always_comb begin
    if (req_x > lim_x) h_x = lim_x;
    else if (req_x < -10'sd1) h_x = -10'sd1;
    else h_x = req_x;
  end

  // lowest free layer
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = LAYERS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = LW'(i);
      end
    end
  end

  // move target and cell control
  assign tgt    = (in_op == OP_FREE) ? '1 : HW'(h_x);
  assign moving = fire && valid_layer && ((in_op == OP_SET) || (in_op == OP_FREE))
                  && (tgt != old_h);

  always_comb begin
    ctrl          = '0;
    ctrl.mode     = SH_NONE;
    ctrl.wr_layer = in_layer;
    top_nxt       = top_r;
    if (moving) begin
      if (old_h > tgt) begin
        if (tgt >= 0) begin
          // move down: positions between shift up by one
          ctrl.mode   = SH_UP;
          ctrl.lo     = HW'(tgt + HW'(1));
          ctrl.hi     = old_h;
          ctrl.wr_en  = 1'b1;
          ctrl.wr_pos = tgt[LW-1:0];
        end else begin
          // hide: layers above close the gap
          ctrl.mode = SH_DN;
          ctrl.lo   = old_h;
          ctrl.hi   = HW'(top_r - HW'(1));
          top_nxt   = HW'(top_r - HW'(1));
        end
      end else begin
        if (old_h >= 0) begin
          // move up: positions between shift down by one
          ctrl.mode   = SH_DN;
          ctrl.lo     = old_h;
          ctrl.hi     = HW'(tgt - HW'(1));
          ctrl.wr_en  = 1'b1;
          ctrl.wr_pos = tgt[LW-1:0];
        end else begin
          // show: insert and push the upper layers up
          ctrl.mode   = SH_UP;
          ctrl.lo     = HW'(tgt + HW'(1));
          ctrl.hi     = HW'(top_r + HW'(1));
          ctrl.wr_en  = 1'b1;
          ctrl.wr_pos = tgt[LW-1:0];
          top_nxt     = HW'(top_r + HW'(1));
        end
      end
    end
  end

  // read position check
  assign rd_ok = (req_x >= 10'sd0) && (req_x <= 10'(top_r));

  // result and pool update
  always_comb begin
    status_nxt = ST_OK;
    id_nxt     = '0;
    lh_nxt     = '1;
    redraw_nxt = moving;
    in_use_nxt = in_use_r;
    if (in_op == OP_ALLOC) begin
      if (free_found) begin
        id_nxt               = free_idx;
        in_use_nxt[free_idx] = 1'b1;
      end else begin
        status_nxt = ST_FULL;
      end
    end else if (!valid_layer) begin
      status_nxt = ST_NOT_USED;
    end else begin
      case (in_op)
        OP_SET:  lh_nxt = tgt;
        OP_FREE: in_use_nxt[in_layer] = 1'b0;
        OP_READ: begin
          lh_nxt = old_h;
          if (rd_ok) id_nxt = entries[req_x[LW-1:0]];
          else status_nxt = ST_EMPTY;
        end
        default: lh_nxt = '1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '1;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        top_r       <= top_nxt;
        in_use_r    <= in_use_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= status_nxt;
      id_r     <= id_nxt;
      lh_r     <= lh_nxt;
      redraw_r <= redraw_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_layer_id     = id_r;
  assign out_layer_height = lh_r;
  assign out_top_height   = top_r;
  assign out_needs_redraw = redraw_r;

  // shown layers are always a subset of the layers in use
  `ASSERT_NEVER(a_shown_le_used, clk, rst_n, (top_r >= 0) && ($countones(in_use_r) <= int'(top_r)))
  // an allocate with a free layer left never reports a full pool
  `ASSERT_CLK(a_alloc_ok, clk, rst_n, (fire && (in_op == OP_ALLOC) && !(&in_use_r)) |=> (status_r == ST_OK))
  // a free on a layer in use releases it
  `ASSERT_CLK(a_free_rel, clk, rst_n, (fire && (in_op == OP_FREE) && valid_layer) |=> !in_use_r[$past(in_layer)])

endmodule
